>>> design/lsq_pkg.sv
// Package for the least-squares slope block.
// Holds field widths, status codes and the controller/datapath command types.
// No dependencies.
`default_nettype none
package lsq_pkg;

  localparam int unsigned X_W     = 16;
  localparam int unsigned Y_W     = 24;
  localparam int unsigned SLOPE_W = 48;
  localparam int unsigned MEAN_W  = 40;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned DIV_W   = 80;
  localparam int unsigned REM_W   = ACC_W + 1;
  localparam int unsigned STEP_W  = 7;
  localparam int unsigned DIV_STEPS  = DIV_W;
  localparam int unsigned DRAIN_LAST = 2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FLAT_X  = 2'd2;

  typedef struct packed {
    logic load;
    logic pass_init;
    logic pass_rd;
    logic div_mean_ld;
    logic div_slope_ld;
    logic div_step;
    logic mean_save;
    logic publish;
  } lsq_cmd_t;

  typedef struct packed {
    logic pass_last;
  } lsq_sts_t;

endpackage
`default_nettype wire

>>> design/lsq_if.sv
// Sample and result channels of the least-squares slope block.
// Depends on lsq_pkg for field widths.
`default_nettype none
interface lsq_in_if;
  logic                     valid;
  logic                     ready;
  logic [lsq_pkg::X_W-1:0]  day_number;
  logic [lsq_pkg::Y_W-1:0]  close_price;
  logic                     last_sample;
  modport source (output valid, day_number, close_price, last_sample, input ready);
  modport sink   (input valid, day_number, close_price, last_sample, output ready);
endinterface

interface lsq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lsq_pkg::SLOPE_W-1:0] slope;
  logic [lsq_pkg::MEAN_W-1:0]         mean_price;
  logic [lsq_pkg::COUNT_W-1:0]        sample_count;
  logic [lsq_pkg::STAT_W-1:0]         fit_status;
  modport source (output valid, slope, mean_price, sample_count, fit_status, input ready);
  modport sink   (input valid, slope, mean_price, sample_count, fit_status, output ready);
endinterface
`default_nettype wire

>>> design/lsq_ctrl.sv
// Sequencer of the least-squares slope block: load, second pass, two divisions.
// Depends on lsq_pkg.
`default_nettype none
module lsq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_last_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output lsq_pkg::lsq_cmd_t      cmd_o,
  input  wire lsq_pkg::lsq_sts_t sts_i
);
  import lsq_pkg::*;

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_PASS  = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_DIVM  = 7'b0001000,
    S_MSAVE = 7'b0010000,
    S_DIVS  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.pass_init = 1'b1;
            state_d = S_PASS;
          end
        end
      end
      S_PASS: begin
        cmd_o.pass_rd = 1'b1;
        if (sts_i.pass_last) begin
          step_d  = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // let the last products reach the accumulators
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DRAIN_LAST)) begin
          cmd_o.div_mean_ld = 1'b1;
          step_d  = '0;
          state_d = S_DIVM;
        end
      end
      S_DIVM: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = S_MSAVE;
      end
      S_MSAVE: begin
        cmd_o.mean_save    = 1'b1;
        cmd_o.div_slope_ld = 1'b1;
        step_d  = '0;
        state_d = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

>>> design/lsq_dp.sv
// Datapath of the least-squares slope block: sample store, sums, second-pass
// multiply-accumulate, shared restoring divider and output register. Uses lsq_pkg.
`default_nettype none
module lsq_dp #(
  parameter int unsigned MAX_SAMPLES = 512
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire lsq_pkg::lsq_cmd_t         cmd_i,
  output lsq_pkg::lsq_sts_t              sts_o,
  input  wire logic [lsq_pkg::X_W-1:0]   day_number_i,
  input  wire logic [lsq_pkg::Y_W-1:0]   close_price_i,
  output logic signed [lsq_pkg::SLOPE_W-1:0] slope_o,
  output logic [lsq_pkg::MEAN_W-1:0]     mean_price_o,
  output logic [lsq_pkg::COUNT_W-1:0]    sample_count_o,
  output logic [lsq_pkg::STAT_W-1:0]     fit_status_o
);
  import lsq_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW   = $clog2(MAX_SAMPLES);
  localparam int unsigned SXW  = X_W + CW;
  localparam int unsigned SYW  = Y_W + CW;
  localparam int unsigned DXW  = SXW + 1;
  localparam int unsigned PYW  = DXW + Y_W + 1;
  localparam int unsigned PXW  = DXW + X_W + 1;
  localparam int unsigned MW   = X_W + Y_W;

  // load side
  logic [MW-1:0]  mem [MAX_SAMPLES];
  logic [CW-1:0]  cnt_q;
  logic [SXW-1:0] sum_x_q;
  logic [SYW-1:0] sum_y_q;
  logic           full;

  assign full = (cnt_q == CW'(MAX_SAMPLES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) mem[cnt_q[AW-1:0]] <= {day_number_i, close_price_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else if (cmd_i.publish) begin
      cnt_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else if (cmd_i.load && !full) begin
      cnt_q   <= cnt_q + 1'b1;
      sum_x_q <= sum_x_q + SXW'(day_number_i);
      sum_y_q <= sum_y_q + SYW'(close_price_i);
    end
  end

  // second pass: read -> centre -> multiply -> accumulate
  logic [AW-1:0]   rd_addr_q;
  logic [MW-1:0]   rd_data_q;
  logic            v1_q, v2_q, v3_q;
  logic signed [DXW-1:0] dx_q;
  logic [X_W-1:0]  x2_q;
  logic [Y_W-1:0]  y2_q;
  logic signed [PYW-1:0] py_q;
  logic signed [PXW-1:0] px_q;
  logic signed [ACC_W-1:0] num_q, den_q;
  logic [SXW-1:0]  nx;

  assign sts_o.pass_last = ({1'b0, rd_addr_q} == (AW+1)'(cnt_q - 1'b1));
  assign nx = SXW'(cnt_q) * SXW'(rd_data_q[MW-1:Y_W]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pass_rd) rd_data_q <= mem[rd_addr_q];
    dx_q <= $signed({1'b0, nx}) - $signed({1'b0, sum_x_q});
    x2_q <= rd_data_q[MW-1:Y_W];
    y2_q <= rd_data_q[Y_W-1:0];
    py_q <= dx_q * $signed({1'b0, y2_q});
    px_q <= dx_q * $signed({1'b0, x2_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      num_q <= '0;
      den_q <= '0;
    end else begin
      v1_q <= cmd_i.pass_rd;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.pass_init) begin
        rd_addr_q <= '0;
        num_q <= '0;
        den_q <= '0;
      end else begin
        if (cmd_i.pass_rd) rd_addr_q <= rd_addr_q + 1'b1;
        if (v3_q) begin
          num_q <= num_q + {{(ACC_W-PYW){py_q[PYW-1]}}, py_q};
          den_q <= den_q + {{(ACC_W-PXW){px_q[PXW-1]}}, px_q};
        end
      end
    end
  end

  // shared restoring divider, one quotient bit a cycle
  logic [REM_W-1:0] rem_q;
  logic [DIV_W-1:0] quo_q;
  logic [ACC_W-1:0] dvs_q;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] dvs_ext;
  logic             den_pos;
  logic             num_neg;
  logic [ACC_W-1:0] num_mag;
  logic [SYW+FRAC_W-1:0] mean_dvd;

  assign trial    = {rem_q[REM_W-2:0], quo_q[DIV_W-1]};
  assign dvs_ext  = {1'b0, dvs_q};
  assign den_pos  = !den_q[ACC_W-1] && (den_q != '0);
  assign num_neg  = num_q[ACC_W-1];
  assign num_mag  = num_neg ? ACC_W'(-num_q) : ACC_W'(num_q);
  assign mean_dvd = {sum_y_q, {FRAC_W{1'b0}}} + (SYW+FRAC_W)'(cnt_q >> 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_mean_ld) begin
      rem_q <= '0;
      quo_q <= DIV_W'(mean_dvd);
      dvs_q <= ACC_W'(cnt_q);
    end else if (cmd_i.div_slope_ld) begin
      rem_q <= '0;
      quo_q <= DIV_W'({num_mag, {FRAC_W{1'b0}}});
      dvs_q <= den_pos ? den_q : ACC_W'(1);
    end else if (cmd_i.div_step) begin
      if (trial >= dvs_ext) begin
        rem_q <= trial - dvs_ext;
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  // slope: round magnitude, saturate, apply sign
  logic [MEAN_W-1:0]  mean_q;
  logic               big;
  logic               rnd;
  logic [SLOPE_W:0]   mag;
  logic [SLOPE_W-1:0] slope_v;
  localparam logic [SLOPE_W:0] POS_MAX = {2'b00, {(SLOPE_W-1){1'b1}}};
  localparam logic [SLOPE_W:0] NEG_MAG = {2'b01, {(SLOPE_W-1){1'b0}}};

  assign big = |quo_q[DIV_W-1:SLOPE_W-1];
  assign rnd = ({rem_q, 1'b0} >= {1'b0, dvs_ext});
  assign mag = {2'b00, quo_q[SLOPE_W-2:0]} + (SLOPE_W+1)'(rnd);

  always_comb begin
    if (num_neg) begin
      if (big || mag > NEG_MAG) slope_v = NEG_MAG[SLOPE_W-1:0];
      else                      slope_v = SLOPE_W'(-mag);
    end else begin
      if (big || mag > POS_MAX) slope_v = POS_MAX[SLOPE_W-1:0];
      else                      slope_v = mag[SLOPE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_save) mean_q <= quo_q[MEAN_W-1:0];
    if (cmd_i.publish) begin
      sample_count_o <= COUNT_W'(cnt_q);
      if (cnt_q == '0) begin
        slope_o      <= '0;
        mean_price_o <= '0;
        fit_status_o <= STAT_EMPTY;
      end else if (!den_pos) begin
        slope_o      <= '0;
        mean_price_o <= mean_q;
        fit_status_o <= STAT_FLAT_X;
      end else begin
        slope_o      <= $signed(slope_v);
        mean_price_o <= mean_q;
        fit_status_o <= STAT_OK;
      end
    end
  end
endmodule
`default_nettype wire

>>> design/least_squares_slope_top.sv
// Top level of the least-squares slope block: controller plus datapath.
// Depends on lsq_pkg, lsq_if, lsq_ctrl and lsq_dp.
//
// Samples (day number, close price) load one per cycle into a store of
// MAX_SAMPLES entries; samples beyond that are dropped. The sample marked last
// starts the fit: a second pass reads the store one entry a cycle through the
// read, centre, multiply and accumulate stages, then one shared restoring
// divider produces the mean and then the slope at one quotient bit a cycle.
// No sample is taken until the result is offered. Slope and mean carry 16
// fraction bits; fit_status flags an empty set or zero spread in x.
`default_nettype none
module least_squares_slope_top #(
  parameter int unsigned MAX_SAMPLES = 512
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lsq_in_if.sink    sample_if,
  lsq_out_if.source result_if
);
  import lsq_pkg::*;

  lsq_cmd_t cmd;
  lsq_sts_t sts;

  lsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_if.valid),
    .in_last_i   (sample_if.last_sample),
    .in_ready_o  (sample_if.ready),
    .out_valid_o (result_if.valid),
    .out_ready_i (result_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lsq_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .day_number_i   (sample_if.day_number),
    .close_price_i  (sample_if.close_price),
    .slope_o        (result_if.slope),
    .mean_price_o   (result_if.mean_price),
    .sample_count_o (result_if.sample_count),
    .fit_status_o   (result_if.fit_status)
  );
endmodule
`default_nettype wire
